@@ src/first_fit_page_allocator_assert.svh @@
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define FFPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("first_fit_page_allocator: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define FFPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("first_fit_page_allocator: assertion failed");

`endif

@@ src/ffpa_pkg.sv @@
// Shared constants, codes and types of the first-fit page allocator.
`default_nettype none

package ffpa_pkg;

   localparam int ENTRIES = 64;
   localparam int ADDR_W  = 48;
   localparam int LEN_W   = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TOP     = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOMATCH = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_LOW      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_CEILING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_BASE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_SIZE = 2'd3;

   // Search token that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic              active;
      logic              op;
      logic              hit;
      logic [CNT_W-1:0]  left;   // records still ahead of the token
      logic [LEN_W-1:0]  size;
      logic [ADDR_W-1:0] addr;   // free address in, granted base out
      logic [ADDR_W:0]   tail;   // newest record's base + length
   } token_type;

   // Append write into one cell.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  len;
   } wr_type;

endpackage

`default_nettype wire

@@ src/ffpa_cell.sv @@
// One allocation record cell: holds base, length and used mark, forwards the token.
`default_nettype none

module ffpa_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ffpa_pkg::token_type tok_i,
   input  wire logic               wr_en,
   input  wire logic [ffpa_pkg::ADDR_W-1:0] wr_base,
   input  wire logic [ffpa_pkg::LEN_W-1:0]  wr_len,
   output ffpa_pkg::token_type      tok_o
);
   import ffpa_pkg::*;

   logic [ADDR_W-1:0] base_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              used_ff;
   logic              used_in;
   token_type         tok_ff;
   token_type         tok_in;
   logic              eligible;
   logic              alloc_match;
   logic              free_match;

   assign eligible    = tok_i.active && (tok_i.left != '0) && !tok_i.hit;
   assign alloc_match = eligible && (tok_i.op == OP_ALLOC) && !used_ff
                        && (len_ff >= tok_i.size);
   assign free_match  = eligible && (tok_i.op == OP_FREE) && used_ff
                        && (base_ff == tok_i.addr);

   always_comb begin
      tok_in = tok_i;
      if (tok_i.left != '0) begin
         tok_in.left = tok_i.left - CNT_W'(1);
      end
      if (alloc_match) begin
         tok_in.hit  = 1'b1;
         tok_in.addr = base_ff;
      end
      if (free_match) begin
         tok_in.hit = 1'b1;
      end
      // last stored record supplies the append point
      if (tok_i.active && (tok_i.left == CNT_W'(1))) begin
         tok_in.tail = {1'b0, base_ff} + {{(ADDR_W + 1 - LEN_W){1'b0}}, len_ff};
      end
   end

   always_comb begin
      used_in = used_ff;
      if (wr_en || alloc_match) begin
         used_in = 1'b1;
      end else if (free_match) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         base_ff <= wr_base;
         len_ff  <= wr_len;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

@@ src/ffpa_chain.sv @@
// Row of record cells with the append write decode.
`default_nettype none

module ffpa_chain (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ffpa_pkg::token_type tok_i,
   input  wire ffpa_pkg::wr_type    wr,
   output ffpa_pkg::token_type      tok_o
);
   import ffpa_pkg::*;

   token_type link [ENTRIES+1];

   assign link[0] = tok_i;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic sel;
      assign sel = wr.en && (wr.index == IDX_W'(i));
      ffpa_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_i   (link[i]),
         .wr_en   (sel),
         .wr_base (wr.base),
         .wr_len  (wr.len),
         .tok_o   (link[i+1])
      );
   end

   assign tok_o = link[ENTRIES];

endmodule

`default_nettype wire

@@ src/ffpa_ctrl.sv @@
// Request sequencer: launches the search token, resolves appends, holds the response.
`default_nettype none

module ffpa_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_operation,
   input  wire logic [ffpa_pkg::LEN_W-1:0]  req_request_size,
   input  wire logic [ffpa_pkg::ADDR_W-1:0] req_free_address,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [ffpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic [1:0]                       rsp_status,
   input  wire logic [ffpa_pkg::ADDR_W-1:0] mem_low,
   input  wire logic [ffpa_pkg::ADDR_W-1:0] addr_ceiling,
   input  wire logic [ffpa_pkg::ADDR_W-1:0] reserve_base,
   input  wire logic [ffpa_pkg::ADDR_W-1:0] reserve_size,
   output ffpa_pkg::token_type              launch,
   input  wire ffpa_pkg::token_type         scan_done,
   output ffpa_pkg::wr_type                 wr
);
   import ffpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_CHECK, S_APPEND, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   token_type         launch_ff, launch_in;
   wr_type            wr_ff, wr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              op_ff, op_in;
   logic [LEN_W-1:0]  size_ff, size_in;
   logic [ADDR_W:0]   base_ff, base_in;
   logic [ADDR_W:0]   end_ff, end_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              in_window;
   logic [ADDR_W-1:0] final_base;

   assign in_window  = (base_ff >= {1'b0, reserve_base}) && (base_ff < end_ff);
   assign final_base = in_window ? end_ff[ADDR_W-1:0] : base_ff[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      launch_in     = launch_ff;
      launch_in.active = 1'b0;
      wr_in         = wr_ff;
      wr_in.en      = 1'b0;
      count_in      = count_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               launch_in.active = 1'b1;
               launch_in.op     = req_operation;
               launch_in.hit    = 1'b0;
               launch_in.left   = count_ff;
               launch_in.size   = req_request_size;
               launch_in.addr   = req_free_address;
               launch_in.tail   = '0;
               op_in            = req_operation;
               size_in          = req_request_size;
               state_in         = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done.active) begin
               res_addr_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               if (scan_done.hit) begin
                  if (op_ff == OP_ALLOC) begin
                     res_addr_in = scan_done.addr;
                  end
               end else if (op_ff == OP_FREE) begin
                  res_status_in = ST_NOMATCH;
               end else if (count_ff == CNT_W'(ENTRIES)) begin
                  res_status_in = ST_FULL;
               end else begin
                  base_in  = (count_ff == '0) ? {1'b0, mem_low} : scan_done.tail;
                  end_in   = {1'b0, reserve_base} + {1'b0, reserve_size};
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (base_ff > {1'b0, addr_ceiling}) begin
               res_addr_in   = '0;
               res_status_in = ST_TOP;
               state_in      = S_DONE;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            wr_in.en      = 1'b1;
            wr_in.index   = count_ff[IDX_W-1:0];
            wr_in.base    = final_base;
            wr_in.len     = size_ff;
            count_in      = count_ff + CNT_W'(1);
            res_addr_in   = final_base;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= '0;
         wr_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         wr_ff        <= wr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff         <= op_in;
         size_ff       <= size_in;
         base_ff       <= base_in;
         end_ff        <= end_in;
         res_addr_ff   <= res_addr_in;
         res_status_ff <= res_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign launch              = launch_ff;
   assign wr                  = wr_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

`default_nettype wire

@@ src/first_fit_page_allocator.sv @@
// Top level of the first-fit page allocator: CSRs, sequencer and record cell row.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | operation, request_size, free_address
//  rsp     | out       | rsp_valid/rsp_stall  | granted_address, status
//  csr     | in        | csr_write            | csr_index, csr_data
//
// Each request sends a token down the row of ENTRIES cells, one cell per cycle.
// A hit, a free or a full table goes from the scan straight to the response; beyond
// memory top passes the top check first; an append passes the check and the write.
// One request is in flight at a time; a finished response may wait in the output
// register while the next request is taken. A stalled response delays only the
// return to idle. Reset is synchronous; the cell row needs no clearing pass.
`default_nettype none

module first_fit_page_allocator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_operation,
   input  wire logic [ffpa_pkg::LEN_W-1:0]          req_request_size,
   input  wire logic [ffpa_pkg::ADDR_W-1:0]         req_free_address,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ffpa_pkg::ADDR_W-1:0]              rsp_granted_address,
   output logic [1:0]                               rsp_status,
   input  wire logic                                csr_write,
   input  wire logic [ffpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ffpa_pkg::ADDR_W-1:0]         csr_data
);
   import ffpa_pkg::*;

   logic [ADDR_W-1:0] mem_low_ff;
   logic [ADDR_W-1:0] addr_ceiling_ff;
   logic [ADDR_W-1:0] reserve_base_ff;
   logic [ADDR_W-1:0] reserve_size_ff;
   token_type         launch;
   token_type         scan_done;
   wr_type            wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_low_ff      <= '0;
         addr_ceiling_ff <= '1;
         reserve_base_ff <= '0;
         reserve_size_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MEM_LOW:      mem_low_ff      <= csr_data;
            CSR_ADDR_CEILING: addr_ceiling_ff <= csr_data;
            CSR_RESERVE_BASE: reserve_base_ff <= csr_data;
            CSR_RESERVE_SIZE: reserve_size_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ffpa_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .mem_low             (mem_low_ff),
      .addr_ceiling        (addr_ceiling_ff),
      .reserve_base        (reserve_base_ff),
      .reserve_size        (reserve_size_ff),
      .launch              (launch),
      .scan_done           (scan_done),
      .wr                  (wr)
   );

   ffpa_chain u_chain (
      .clock (clock),
      .reset (reset),
      .tok_i (launch),
      .wr    (wr),
      .tok_o (scan_done)
   );

endmodule

`default_nettype wire

@@ src/ffpa_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
`default_nettype none

`include "first_fit_page_allocator_assert.svh"

module ffpa_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [ffpa_pkg::ADDR_W-1:0] rsp_granted_address,
   input wire logic [1:0]                  rsp_status
);
   import ffpa_pkg::*;

   // a held response keeps its payload
   `FFPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_granted_address) && $stable(rsp_status))

   // failures never report an address
   `FFPA_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_granted_address == '0)

   // one request at a time: a transfer closes the request port
   `FFPA_ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && !req_stall, req_stall)

   // reset empties the response register
   `FFPA_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_granted_address (rsp_granted_address),
   .rsp_status          (rsp_status)
);

`default_nettype wire

@@ test/tb_first_fit_page_allocator.sv @@
// Self-checking testbench for the first-fit page allocator: directed and random requests.
module tb_first_fit_page_allocator;
   import ffpa_pkg::*;

   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int BATCH        = 500;
   localparam int SETTLE       = ENTRIES + 8;

   typedef struct packed {
      logic              op;
      logic [LEN_W-1:0]  size;
      logic [ADDR_W-1:0] addr;
   } alloc_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted;
      logic [1:0]        status;
   } alloc_resp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_operation = OP_ALLOC;
   logic [LEN_W-1:0]  req_request_size = '0;
   logic [ADDR_W-1:0] req_free_address = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_granted_address;
   logic [1:0]        rsp_status;
   logic              csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MEM_LOW;
   logic [ADDR_W-1:0] csr_data = '0;

   // register copies and record table as the block should hold them
   logic [ADDR_W-1:0] cfg_low = '0;
   logic [ADDR_W-1:0] cfg_high = '1;
   logic [ADDR_W-1:0] cfg_rbase = '0;
   logic [ADDR_W-1:0] cfg_rsize = '0;
   logic [ADDR_W-1:0] rec_base [ENTRIES];
   logic [LEN_W-1:0]  rec_len [ENTRIES];
   logic              rec_used [ENTRIES] = '{default: 1'b0};
   int                rec_count = 0;

   alloc_req_type  pending_requests[$];
   alloc_resp_type expected_responses[$];
   int n_queued = 0;
   int n_presented = 0;
   int n_accepted = 0;
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   first_fit_page_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Base the next appended record would get, one bit wider so a carry shows.
   function automatic logic [ADDR_W:0] append_base();
      if (rec_count == 0)
         return {1'b0, cfg_low};
      return {1'b0, rec_base[rec_count-1]} + (ADDR_W+1)'(rec_len[rec_count-1]);
   endfunction

   function automatic alloc_resp_type allocate_or_free(input alloc_req_type rq);
      alloc_resp_type  rs;
      logic            hit;
      logic [ADDR_W:0] base;
      logic [ADDR_W:0] win_end;
      rs.granted = '0;
      rs.status  = ST_OK;
      hit = 1'b0;
      if (rq.op == OP_FREE) begin
         for (int i = 0; i < rec_count; i++)
            if (!hit && rec_used[i] && rec_base[i] == rq.addr) begin
               rec_used[i] = 1'b0;
               hit = 1'b1;
            end
         if (!hit)
            rs.status = ST_NOMATCH;
         return rs;
      end
      for (int i = 0; i < rec_count; i++)
         if (!hit && !rec_used[i] && rec_len[i] >= rq.size) begin
            rec_used[i] = 1'b1;
            rs.granted = rec_base[i];
            hit = 1'b1;
         end
      if (hit)
         return rs;
      if (rec_count >= ENTRIES) begin
         rs.status = ST_FULL;
         return rs;
      end
      base = append_base();
      if (base > {1'b0, cfg_high}) begin
         rs.status = ST_TOP;
         return rs;
      end
      // top check first, then skip past the reserved window (end wraps to ADDR_W)
      win_end = {1'b0, cfg_rbase} + {1'b0, cfg_rsize};
      if (base >= {1'b0, cfg_rbase} && base < win_end)
         base = win_end;
      rec_base[rec_count] = base[ADDR_W-1:0];
      rec_len[rec_count]  = rq.size;
      rec_used[rec_count] = 1'b1;
      rec_count++;
      rs.granted = base[ADDR_W-1:0];
      return rs;
   endfunction

   // Mostly allocates and frees of live records; the rest is noise.
   function automatic alloc_req_type random_request();
      alloc_req_type rq;
      int pick;
      int start;
      int j;
      logic found;
      pick = $urandom_range(0, 99);
      rq.size = $urandom;
      rq.addr = {16'($urandom), $urandom};
      found = 1'b0;
      if (pick < 45) begin
         rq.op = OP_ALLOC;
         if (pick < 30)
            rq.size = $urandom_range(0, 'h3FFF);
         else if (pick < 38 && rec_count != 0)
            rq.size = rec_len[$urandom_range(0, rec_count - 1)];
      end else begin
         rq.op = OP_FREE;
         if (pick < 88 && rec_count != 0) begin
            start = $urandom_range(0, rec_count - 1);
            rq.addr = rec_base[start];
            for (int k = 0; k < rec_count; k++) begin
               j = (start + k) % rec_count;
               if (!found && rec_used[j]) begin
                  rq.addr = rec_base[j];
                  found = 1'b1;
               end
            end
         end
      end
      return rq;
   endfunction

   task automatic report_mismatch(input string note);
      $display("mismatch at cycle %0d: %s", cycles, note);
      errors++;
   endtask

   task automatic send(input logic op, input logic [LEN_W-1:0] size,
                       input logic [ADDR_W-1:0] addr);
      alloc_req_type rq;
      rq.op = op;
      rq.size = size;
      rq.addr = addr;
      pending_requests.push_back(rq);
      n_queued++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_MEM_LOW:      cfg_low = val;
         CSR_ADDR_CEILING: cfg_high = val;
         CSR_RESERVE_BASE: cfg_rbase = val;
         CSR_RESERVE_SIZE: cfg_rsize = val;
         default: ;
      endcase
   endtask

   task automatic program_map(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                              input logic [ADDR_W-1:0] rb, input logic [ADDR_W-1:0] rs);
      write_csr(CSR_MEM_LOW, lo);
      write_csr(CSR_ADDR_CEILING, hi);
      write_csr(CSR_RESERVE_BASE, rb);
      write_csr(CSR_RESERVE_SIZE, rs);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Hold off until every request is through and answered, then let the block settle.
   task automatic wait_idle();
      while (n_accepted != n_queued || expected_responses.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // driver and receiver stall, both updated on the falling edge
   always @(negedge clock) begin
      logic          v;
      alloc_req_type rq;
      v = req_valid;
      rq.op = req_operation;
      rq.size = req_request_size;
      rq.addr = req_free_address;
      if (reset) begin
         v = 1'b0;
      end else if (n_accepted == n_presented) begin
         v = 1'b0;
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            rq = pending_requests.pop_front();
            v = 1'b1;
            n_presented++;
         end
      end
      req_valid        <= v;
      req_operation    <= rq.op;
      req_request_size <= rq.size;
      req_free_address <= rq.addr;
      rsp_stall        <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      alloc_resp_type want;
      alloc_req_type  rq;
      if (!reset) begin
         // older response first: it can never belong to a request taken on this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding (%h, %0d)",
                                         rsp_granted_address, rsp_status));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_granted_address !== want.granted)
                  report_mismatch($sformatf("granted_address %h, expected %h",
                                            rsp_granted_address, want.granted));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
         end
         if (req_valid && !req_stall) begin
            rq.op = req_operation;
            rq.size = req_request_size;
            rq.addr = req_free_address;
            expected_responses.push_back(allocate_or_free(rq));
            n_accepted++;
         end
      end
   end

   initial begin
      logic [ADDR_W:0] tail;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 70;
      program_map(48'h1000, ADDR_MAX, 48'h4000, 48'h3000);
      send(OP_ALLOC, 32'h1000, '0);         // empty table: starts at mem_low
      send(OP_ALLOC, 32'h2000, ADDR_MAX);
      send(OP_ALLOC, 32'h0, '0);            // lands in the window, moved to its end
      send(OP_ALLOC, 32'h10, '0);           // zero-length record: same base again
      send(OP_FREE, '1, 48'h2000);
      send(OP_FREE, '0, 48'h2000);          // already free: no match
      send(OP_ALLOC, 32'h1800, '0);         // reuses the larger free record whole
      send(OP_FREE, '0, 48'h7000);
      send(OP_FREE, '0, 48'h7000);          // second record with that base
      send(OP_ALLOC, 32'h0, '0);            // zero size takes any free record
      send(OP_ALLOC, 32'hFFFF_FFFF, '0);
      send(OP_FREE, '1, ADDR_MAX);
      send(OP_FREE, '0, '0);
      wait_idle();

      tail = append_base();
      program_map(cfg_low, tail[ADDR_W-1:0] - 1'b1, cfg_rbase, cfg_rsize);
      send(OP_ALLOC, 32'h20, '0);           // one past the top limit
      wait_idle();
      program_map(cfg_low, tail[ADDR_W-1:0], cfg_rbase, cfg_rsize);
      send(OP_ALLOC, 32'h1, '0);            // exactly at the top limit
      wait_idle();

      // window end wraps past the top of the address space
      tail = append_base();
      program_map(cfg_low, ADDR_MAX, tail[ADDR_W-1:0], ADDR_MAX);
      send(OP_ALLOC, 32'h40, '0);
      send(OP_FREE, '0, tail[ADDR_W-1:0] - 1'b1);
      send(OP_ALLOC, 32'h1, '0);
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         tail = append_base();
         case (phase)
            0: program_map('0, tail[ADDR_W-1:0] + 48'h8000, tail[ADDR_W-1:0] + 48'h2000,
                           48'h1000);
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 34;
               program_map(ADDR_MAX, ADDR_MAX, '0, '0);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               program_map(48'h5555_5555_5555, tail[ADDR_W-1:0], ADDR_MAX, ADDR_MAX);
            end
         endcase
         repeat (BATCH) begin
            // keep the lookahead short so frees see an up-to-date table
            while (n_queued - n_accepted >= 2)
               @(negedge clock);
            pending_requests.push_back(random_request());
            n_queued++;
         end
         wait_idle();
      end

      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/ffpa_pkg.sv
src/ffpa_cell.sv
src/ffpa_chain.sv
src/ffpa_ctrl.sv
src/first_fit_page_allocator.sv
src/ffpa_checker.sv
test/tb_first_fit_page_allocator.sv
